/* hdl/ple_pkg.sv */
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int ValW = 32;
	localparam int PosW = 5;
	localparam int ModeW = 3;
	localparam int StatW = 2;
	localparam int CntOutW = 5;

	localparam logic [ModeW-1:0] MODE_INSERT = 3'd0;
	localparam logic [ModeW-1:0] MODE_ERASE  = 3'd1;
	localparam logic [ModeW-1:0] MODE_GETNTH = 3'd2;
	localparam logic [ModeW-1:0] MODE_COUNT  = 3'd3;
	localparam logic [ModeW-1:0] MODE_POP    = 3'd4;

	localparam logic [StatW-1:0] ST_OK     = 2'd0;
	localparam logic [StatW-1:0] ST_BADPOS = 2'd1;
	localparam logic [StatW-1:0] ST_EMPTY  = 2'd2;
	localparam logic [StatW-1:0] ST_FULL   = 2'd3;

	// command broadcast from the controller to every cell
	typedef struct packed {
		logic            ins;    // open a slot at pos, write value there
		logic            del;    // close the slot at pos
		logic            load;   // copy data into the read taps, latch match flags
		logic            step;   // move taps and flags one cell toward the head
		logic [PosW-1:0] pos;
		logic [ValW-1:0] value;
	} ple_cmd_t;

endpackage

/* hdl/ple_cell.sv */
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an element, shifts it toward either neighbor on
// insert/erase, and carries a read tap and a match flag down the chain.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; #(
	parameter int IDX = 0,
	parameter int LW  = 5
) (
	input  logic            clk,
	input  ple_cmd_t        cmd,
	input  logic [LW-1:0]   len,
	input  logic [ValW-1:0] left_data,
	input  logic [ValW-1:0] right_data,
	input  logic [ValW-1:0] right_tap,
	input  logic            right_flag,
	output logic [ValW-1:0] data,
	output logic [ValW-1:0] tap,
	output logic            flag
);

	localparam int CW = (LW > PosW) ? LW : PosW;

	logic [ValW-1:0] data_q;
	logic [ValW-1:0] tap_q;
	logic            flag_q;
	logic [CW-1:0]   idx_c;
	logic [CW-1:0]   pos_c;
	logic [CW-1:0]   len_c;

	assign idx_c = CW'(IDX);
	assign pos_c = CW'(cmd.pos);
	assign len_c = CW'(len);

	always_ff @(posedge clk) begin
		if (cmd.ins && idx_c > pos_c) begin
			data_q <= left_data;
		end else if (cmd.ins && idx_c == pos_c) begin
			data_q <= cmd.value;
		end else if (cmd.del && idx_c >= pos_c) begin
			data_q <= right_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tap_q  <= data_q;
			flag_q <= (data_q == cmd.value) && (idx_c < len_c);
		end else if (cmd.step) begin
			tap_q  <= right_tap;
			flag_q <= right_flag;
		end
	end

	assign data = data_q;
	assign tap  = tap_q;
	assign flag = flag_q;

endmodule

/* hdl/positional_list_engine.sv */
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values kept in a chain of cells.
// ----------------------------------------------------------------------------
// Insert, erase, pop and error cases: result registered in the cycle after the beat.
// Get nth at position p: taps load, then walk p cells toward the head.
// Count: match flags walk the whole chain into one adder.
// One request at a time; next beat taken once the result slot is free.
// arst_n clears the length, the controller and the result valid; cell
// contents are not reset.
module positional_list_engine import ple_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // mode[2:0], value[34:3], position[39:35]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // data_out[31:0], match_count[36:32],
	                              // status[38:37], length[43:39], zero[47:44]
);

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int KW = $clog2(CAPACITY);
	localparam int CW = (LW > PosW) ? LW : PosW;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t state_q;
	logic [LW-1:0] len_q;
	logic [KW-1:0] cnt_q;
	logic [LW-1:0] acc_q;
	logic          is_count_q;

	logic                m_valid_q;
	logic [ValW-1:0]     out_data_q;
	logic [CntOutW-1:0]  out_match_q;
	logic [StatW-1:0]    out_stat_q;
	logic [CntOutW-1:0]  out_len_q;

	logic [ModeW-1:0] in_mode;
	logic [ValW-1:0]  in_value;
	logic [PosW-1:0]  in_pos;
	logic             take;
	logic [CW-1:0]    pos_c;
	logic [CW-1:0]    len_c;
	logic [CW-1:0]    cap_c;

	ple_cmd_t cmd;
	logic     finish;
	logic     go_run;
	logic [StatW-1:0] fin_stat;
	logic [ValW-1:0]  fin_data;
	logic [LW-1:0]    fin_len;
	logic [LW-1:0]    acc_nxt;

	logic [ValW-1:0] data_w [CAPACITY];
	logic [ValW-1:0] tap_w  [CAPACITY];
	logic            flag_w [CAPACITY];

	assign in_mode  = s_tdata[2:0];
	assign in_value = s_tdata[34:3];
	assign in_pos   = s_tdata[39:35];

	assign s_tready = (state_q == S_IDLE) && (!m_valid_q || m_tready);
	assign take     = s_tvalid && s_tready;

	assign pos_c = CW'(in_pos);
	assign len_c = CW'(len_q);
	assign cap_c = CW'(CAPACITY);

	assign acc_nxt = acc_q + LW'(flag_w[0]);

	always_comb begin
		cmd       = '0;
		cmd.value = in_value;
		cmd.pos   = (in_mode == MODE_POP) ? '0 : in_pos;
		finish    = 1'b0;
		go_run    = 1'b0;
		fin_stat  = ST_OK;
		fin_data  = '0;
		fin_len   = len_q;
		if (state_q == S_IDLE) begin
			if (take) begin
				finish = 1'b1;
				unique case (in_mode)
					MODE_INSERT: begin
						if (pos_c > len_c) begin
							fin_stat = ST_BADPOS;
						end else if (len_c == cap_c) begin
							fin_stat = ST_FULL;
						end else begin
							cmd.ins = 1'b1;
							fin_len = len_q + 1'b1;
						end
					end
					MODE_ERASE: begin
						if (pos_c >= len_c) begin
							fin_stat = ST_BADPOS;
						end else begin
							cmd.del = 1'b1;
							fin_len = len_q - 1'b1;
						end
					end
					MODE_GETNTH: begin
						if (len_q == '0) begin
							fin_stat = ST_EMPTY;
						end else if (pos_c >= len_c) begin
							fin_stat = ST_BADPOS;
						end else begin
							finish   = 1'b0;
							go_run   = 1'b1;
							cmd.load = 1'b1;
						end
					end
					MODE_COUNT: begin
						if (len_q == '0) begin
							fin_stat = ST_EMPTY;
						end else begin
							finish   = 1'b0;
							go_run   = 1'b1;
							cmd.load = 1'b1;
						end
					end
					MODE_POP: begin
						if (len_q == '0) begin
							fin_stat = ST_EMPTY;
						end else begin
							cmd.del  = 1'b1;
							fin_data = data_w[0];
							fin_len  = len_q - 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end else begin
			// head tap of the chain holds element (start count - cnt_q) here
			if (cnt_q == '0) begin
				finish = 1'b1;
				if (!is_count_q) begin
					fin_data = tap_w[0];
				end
			end else begin
				cmd.step = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			len_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (go_run) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			len_q <= fin_len;
			if (finish) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_run) begin
			is_count_q <= (in_mode == MODE_COUNT);
			cnt_q      <= (in_mode == MODE_COUNT) ? KW'(CAPACITY - 1) : KW'(in_pos);
			acc_q      <= '0;
		end else if (state_q == S_RUN) begin
			if (is_count_q) begin
				acc_q <= acc_nxt;
			end
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
		if (finish) begin
			out_data_q  <= fin_data;
			out_match_q <= (state_q == S_RUN && is_count_q) ? CntOutW'(acc_nxt) : '0;
			out_stat_q  <= fin_stat;
			out_len_q   <= CntOutW'(fin_len);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ValW-1:0] left_d;
		logic [ValW-1:0] right_d;
		logic [ValW-1:0] right_t;
		logic            right_f;

		if (i == 0) begin : g_head
			assign left_d = '0;
		end else begin : g_mid
			assign left_d = data_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_d = '0;
			assign right_t = '0;
			assign right_f = 1'b0;
		end else begin : g_body
			assign right_d = data_w[i+1];
			assign right_t = tap_w[i+1];
			assign right_f = flag_w[i+1];
		end

		ple_cell #(
			.IDX (i),
			.LW  (LW)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.len        (len_q),
			.left_data  (left_d),
			.right_data (right_d),
			.right_tap  (right_t),
			.right_flag (right_f),
			.data       (data_w[i]),
			.tap        (tap_w[i]),
			.flag       (flag_w[i])
		);
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0, out_len_q, out_stat_q, out_match_q, out_data_q};

endmodule
